@@ src/imm_pkg.sv @@
`default_nettype none

package imm_pkg;

	// Field widths of the request and result channels.
	localparam int KIND_W  = 2;
	localparam int DIM_W   = 3;
	localparam int VALUE_W = 16;
	localparam int SUM_W   = 35;
	localparam int SIZE_W  = 4;

	// Reset value of the active size register.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

endpackage

`default_nettype wire

@@ src/imm_cmd_if.sv @@
`default_nettype none

interface imm_cmd_if import imm_pkg::*; ();

	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic [DIM_W-1:0]          row;
	logic [DIM_W-1:0]          col;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, kind, row, col, value, input ready);
	modport sink (input valid, kind, row, col, value, output ready);

endinterface

`default_nettype wire

@@ src/imm_rsp_if.sv @@
`default_nettype none

interface imm_rsp_if import imm_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic [DIM_W-1:0]        out_row;
	logic [DIM_W-1:0]        out_col;
	logic signed [SUM_W-1:0] sum;
	logic                    last;

	modport source (output valid, out_row, out_col, sum, last, input ready);
	modport sink (input valid, out_row, out_col, sum, last, output ready);

endinterface

`default_nettype wire

@@ src/int_matrix_multiply_unit.sv @@
// Channel   | Direction | Handshake     | Payload
// cmd       | in        | valid / ready | kind, row, col, value
// rsp       | out       | valid / ready | out_row, out_col, sum, last
// cfg       | in        | cfg_we        | cfg_wdata (active size)
//
// Loads are accepted back to back. A compute request runs N*N*N
// multiply-accumulate steps, one per cycle through the single multiplier
// while no result stalls, through the read, multiply and result registers;
// the next request is accepted after the last result has been taken.
// Reset clears control state only; matrix stores hold no reset value.
// A stalled result freezes the whole read/multiply/accumulate pipeline.
`default_nettype none

module int_matrix_multiply_unit import imm_pkg::*; #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	imm_cmd_if.sink                cmd,
	imm_rsp_if.source              rsp,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_wdata
);

	localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int PROD_W    = 2 * ELEM_BITS;
	localparam int EXT_W     = (PROD_W > SUM_W) ? PROD_W : SUM_W;
	localparam int VEXT_W    = (ELEM_BITS > VALUE_W) ? ELEM_BITS : VALUE_W;

	// Matrix stores.
	logic signed [ELEM_BITS-1:0] mem_a [MEM_DEPTH];
	logic signed [ELEM_BITS-1:0] mem_b [MEM_DEPTH];

	// Control state.
	logic [SIZE_W-1:0] size_q;
	logic              busy_q;
	logic              issue_q;
	logic [DIM_W-1:0]  nm1_q;
	logic [DIM_W-1:0]  i_q, j_q, k_q;

	// Pipeline stages.
	logic                        v_s1, v_s2;
	logic signed [ELEM_BITS-1:0] rd_a_s1, rd_b_s1;
	logic                        first_s1, lastk_s1, lastel_s1;
	logic [DIM_W-1:0]            i_s1, j_s1;
	logic signed [SUM_W-1:0]     prod_s2;
	logic                        first_s2, lastk_s2, lastel_s2;
	logic [DIM_W-1:0]            i_s2, j_s2;
	logic signed [SUM_W-1:0]     acc_q;

	// Result register.
	logic                    out_valid_q;
	logic [DIM_W-1:0]        out_row_q, out_col_q;
	logic signed [SUM_W-1:0] out_sum_q;
	logic                    out_last_q;

	logic                        adv;
	logic                        cmd_acc;
	logic                        wr_en;
	logic [ADDR_W-1:0]           wr_addr;
	logic signed [VEXT_W-1:0]    val_ext;
	logic signed [ELEM_BITS-1:0] elem;
	logic [ADDR_W-1:0]           a_raddr, b_raddr;
	logic [SIZE_W-1:0]           n_act;
	logic signed [PROD_W-1:0]    prod_full;
	logic signed [EXT_W-1:0]     prod_ext;
	logic signed [SUM_W-1:0]     sum_new;

	// The pipeline moves unless a finished result is waiting.
	assign adv     = !(out_valid_q && !rsp.ready);
	assign cmd_acc = cmd.valid && cmd.ready;

	assign cmd.ready = !busy_q;

	// Load decode: in-range element writes only.
	assign wr_en = cmd_acc && (cmd.kind == KIND_LOAD_A || cmd.kind == KIND_LOAD_B)
		&& ({1'b0, cmd.row} < (DIM_W + 1)'(MAX_DIM))
		&& ({1'b0, cmd.col} < (DIM_W + 1)'(MAX_DIM));
	assign wr_addr = {cmd.row[IDX_W-1:0], cmd.col[IDX_W-1:0]};
	assign val_ext = VEXT_W'(cmd.value);
	assign elem    = val_ext[ELEM_BITS-1:0];

	// Read addresses for A[i][k] and B[k][j].
	assign a_raddr = {i_q[IDX_W-1:0], k_q[IDX_W-1:0]};
	assign b_raddr = {k_q[IDX_W-1:0], j_q[IDX_W-1:0]};

	// Active size, clamped to 1..MAX_DIM.
	always_comb begin
		if (size_q == '0) begin
			n_act = SIZE_W'(1);
		end else if (size_q > SIZE_W'(MAX_DIM)) begin
			n_act = SIZE_W'(MAX_DIM);
		end else begin
			n_act = size_q;
		end
	end

	// Store writes and registered reads.
	always_ff @(posedge clk) begin
		if (wr_en && cmd.kind == KIND_LOAD_A) begin
			mem_a[wr_addr] <= elem;
		end
		if (adv) begin
			rd_a_s1 <= mem_a[a_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && cmd.kind == KIND_LOAD_B) begin
			mem_b[wr_addr] <= elem;
		end
		if (adv) begin
			rd_b_s1 <= mem_b[b_raddr];
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// Index sequencer over i, j, k and the busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= 1'b0;
			nm1_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			if (cmd_acc && cmd.kind == KIND_COMPUTE) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				nm1_q   <= DIM_W'(n_act - SIZE_W'(1));
				i_q     <= '0;
				j_q     <= '0;
				k_q     <= '0;
			end else if (issue_q && adv) begin
				if (k_q == nm1_q) begin
					k_q <= '0;
					if (j_q == nm1_q) begin
						j_q <= '0;
						if (i_q == nm1_q) begin
							issue_q <= 1'b0;
						end else begin
							i_q <= i_q + DIM_W'(1);
						end
					end else begin
						j_q <= j_q + DIM_W'(1);
					end
				end else begin
					k_q <= k_q + DIM_W'(1);
				end
			end
			if (rsp.valid && rsp.ready && rsp.last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue_q;
			v_s2 <= v_s1;
		end
	end

	// Multiply stage.
	assign prod_full = rd_a_s1 * rd_b_s1;
	assign prod_ext  = EXT_W'(prod_full);

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1  <= (k_q == '0);
			lastk_s1  <= (k_q == nm1_q);
			lastel_s1 <= (i_q == nm1_q) && (j_q == nm1_q);
			i_s1      <= i_q;
			j_s1      <= j_q;
			prod_s2   <= prod_ext[SUM_W-1:0];
			first_s2  <= first_s1;
			lastk_s2  <= lastk_s1;
			lastel_s2 <= lastel_s1;
			i_s2      <= i_s1;
			j_s2      <= j_s1;
		end
	end

	// Accumulate stage; the sum wraps at its 35 bits.
	assign sum_new = first_s2 ? prod_s2 : acc_q + prod_s2;

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			acc_q <= sum_new;
			if (lastk_s2) begin
				out_row_q  <= i_s2;
				out_col_q  <= j_s2;
				out_sum_q  <= sum_new;
				out_last_q <= lastel_s2;
			end
		end
	end

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && v_s2 && lastk_s2) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.out_row = out_row_q;
	assign rsp.out_col = out_col_q;
	assign rsp.sum     = out_sum_q;
	assign rsp.last    = out_last_q;

	// Results appear only while a compute request is in progress.
	a_rsp_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> busy_q)
		else $error("result outside a compute request");

	// A request is taken only when the pipeline is empty.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (!issue_q && !v_s1 && !v_s2 && !rsp.valid))
		else $error("request accepted while pipeline busy");

	// A compute request starts the sequencer.
	a_compute_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && cmd.kind == KIND_COMPUTE) |=> issue_q)
		else $error("compute request did not start issue");

	// A stalled result freezes the accumulator.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable(acc_q))
		else $error("accumulator moved during stall");

endmodule

`default_nettype wire
